FILE: sv/drr_pkg.sv
// Package for the deficit round robin scheduler: sizes, request codes, shared types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package drr_pkg;
	localparam int NUM_CLASSES = 3;
	localparam int QUEUE_DEPTH = 1024;
	localparam int CLS_W = 2;
	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = PTR_W + 1;
	localparam int DEF_W = 18;
	localparam int CFG_IDX_W = 3;
	localparam int ADDR_W = $clog2(NUM_CLASSES * QUEUE_DEPTH);
	localparam logic [DEF_W-1:0] DEFICIT_MAX = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PORT_TWO = 3'd0,
		CFG_PORT_ONE = 3'd1,
		CFG_QUANT_ZERO = 3'd2,
		CFG_QUANT_ONE = 3'd3,
		CFG_QUANT_TWO = 3'd4,
		CFG_QUEUE_LIMIT = 3'd5
	} cfg_idx_t;

	typedef enum logic {
		REQ_ENQ = 1'b0,
		REQ_DEQ = 1'b1
	} req_t;

	typedef struct packed {
		req_t req;
		logic [CLS_W-1:0] cls;
		logic [15:0] len;
		logic [15:0] tag;
	} cmd_t;

	typedef struct packed {
		logic enq_accepted;
		logic out_valid;
		logic [15:0] out_tag;
		logic [15:0] out_len;
		logic [CLS_W-1:0] out_class;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ENQ,
		ST_RD,
		ST_EVAL,
		ST_POP,
		ST_OUT
	} state_t;
endpackage
`default_nettype wire

FILE: sv/drr_front.sv
// Front end: classifies requests by source port and queues commands.
// Depends on drr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module drr_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic req_type,
	input wire logic [15:0] src_port,
	input wire logic [15:0] pkt_len,
	input wire logic [15:0] pkt_tag,
	input wire logic [15:0] port_two,
	input wire logic [15:0] port_one,
	output logic cmd_valid,
	input wire logic cmd_ready,
	output drr_pkg::cmd_t cmd
);
	import drr_pkg::*;
	cmd_t q_mem_q [2];
	logic [1:0] cnt_q;
	logic rd_q, wr_q;
	cmd_t c;
	logic [CLS_W-1:0] cls;
	logic push, pop;

	always_comb begin
		if (src_port == port_two) cls = CLS_W'(2);
		else if (src_port == port_one) cls = CLS_W'(1);
		else cls = '0;
		if (cls > CLS_W'(NUM_CLASSES - 1)) cls = CLS_W'(NUM_CLASSES - 1);
		c.req = req_t'(req_type);
		c.cls = cls;
		c.len = pkt_len;
		c.tag = pkt_tag;
	end

	assign in_ready = cnt_q != 2'd2;
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd = q_mem_q[rd_q];
	assign push = in_valid && in_ready;
	assign pop = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) q_mem_q[wr_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q <= 1'b0;
			wr_q <= 1'b0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue count overflow");
	a_nopush_full: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !push) else $error("push into full queue");
	a_pop_dec: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> cnt_q == $past(cnt_q) - 2'd1) else $error("pop count");
endmodule
`default_nettype wire

FILE: sv/drr_back.sv
// Back end: class FIFO memory, deficit rounds and round buffer.
// Depends on drr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module drr_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cmd_valid,
	output logic cmd_ready,
	input wire drr_pkg::cmd_t cmd,
	input wire logic [15:0] quant_zero,
	input wire logic [15:0] quant_one,
	input wire logic [15:0] quant_two,
	input wire logic [10:0] queue_limit,
	output logic res_valid,
	input wire logic res_ready,
	output drr_pkg::res_t res
);
	import drr_pkg::*;
	logic [31:0] mem [NUM_CLASSES * QUEUE_DEPTH];
	logic [31:0] rd_data_q;
	logic [PTR_W-1:0] head_q [NUM_CLASSES];
	logic [PTR_W-1:0] tail_q [NUM_CLASSES];
	logic [CNT_W-1:0] count_q [NUM_CLASSES];
	logic [DEF_W-1:0] deficit_q [NUM_CLASSES];
	logic [33:0] rb_q [NUM_CLASSES];
	logic [1:0] rcnt_q;
	state_t state_q, state_d;
	cmd_t cmd_q;
	logic [CLS_W-1:0] cls_q;
	res_t res_q;
	logic res_valid_q;
	logic [CNT_W-1:0] limit;
	logic [15:0] quant;
	logic [DEF_W:0] dsum;
	logic [DEF_W-1:0] dsat;
	logic fits, take, last_cls;

	assign cmd_ready = state_q == ST_IDLE && (!res_valid_q || res_ready);
	assign res_valid = res_valid_q;
	assign res = res_q;
	assign limit = (queue_limit > 11'(QUEUE_DEPTH)) ? CNT_W'(QUEUE_DEPTH) : CNT_W'(queue_limit);
	assign last_cls = cls_q == CLS_W'(NUM_CLASSES - 1);

	always_comb begin
		case (cls_q)
			CLS_W'(1): quant = quant_one;
			CLS_W'(2): quant = quant_two;
			default: quant = quant_zero;
		endcase
		dsum = {1'b0, deficit_q[cls_q]} + (DEF_W + 1)'(quant);
		dsat = dsum[DEF_W] ? DEFICIT_MAX : dsum[DEF_W-1:0];
		fits = dsat >= DEF_W'(rd_data_q[15:0]);
		take = cmd_valid && cmd_ready;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take) state_d = (cmd.req == REQ_ENQ) ? ST_ENQ
					: (rcnt_q == 2'd0 ? ST_RD : ST_POP);
			end
			ST_ENQ: state_d = ST_IDLE;
			ST_RD: state_d = (count_q[cls_q] == '0) ? (last_cls ? ST_POP : ST_RD) : ST_EVAL;
			ST_EVAL: state_d = last_cls ? ST_POP : ST_RD;
			ST_POP: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_ENQ && count_q[cmd_q.cls] < limit)
			mem[ADDR_W'(cmd_q.cls) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail_q[cmd_q.cls])]
				<= {cmd_q.tag, cmd_q.len};
		rd_data_q <= mem[ADDR_W'(cls_q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head_q[cls_q])];
		if (take) cmd_q <= cmd;
		if (state_q == ST_EVAL && fits && rcnt_q < 2'(NUM_CLASSES))
			rb_q[rcnt_q] <= {rd_data_q[31:16], rd_data_q[15:0], cls_q};
		if (state_q == ST_POP && rcnt_q != 2'd0)
			for (int i = 0; i < NUM_CLASSES - 1; i++) rb_q[i] <= rb_q[i+1];
		if (state_q == ST_ENQ) begin
			res_q <= '0;
			res_q.enq_accepted <= count_q[cmd_q.cls] < limit;
		end
		if (state_q == ST_POP) begin
			res_q <= '0;
			if (rcnt_q != 2'd0) begin
				res_q.out_valid <= 1'b1;
				res_q.out_tag <= rb_q[0][33:18];
				res_q.out_len <= rb_q[0][17:2];
				res_q.out_class <= rb_q[0][1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			res_valid_q <= 1'b0;
			rcnt_q <= '0;
			cls_q <= '0;
			for (int i = 0; i < NUM_CLASSES; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				count_q[i] <= '0;
				deficit_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (res_valid_q && res_ready) res_valid_q <= 1'b0;
			if (state_q == ST_ENQ || state_q == ST_POP) res_valid_q <= 1'b1;
			if (state_q == ST_IDLE) cls_q <= '0;
			if (state_q == ST_RD && count_q[cls_q] == '0 && !last_cls) cls_q <= cls_q + 1'b1;
			if (state_q == ST_EVAL) begin
				if (!last_cls) cls_q <= cls_q + 1'b1;
				deficit_q[cls_q] <= fits ? dsat - DEF_W'(rd_data_q[15:0]) : dsat;
				if (fits) begin
					head_q[cls_q] <= head_q[cls_q] + 1'b1;
					count_q[cls_q] <= count_q[cls_q] - 1'b1;
					if (rcnt_q < 2'(NUM_CLASSES)) rcnt_q <= rcnt_q + 2'd1;
				end
			end
			if (state_q == ST_ENQ && count_q[cmd_q.cls] < limit) begin
				tail_q[cmd_q.cls] <= tail_q[cmd_q.cls] + 1'b1;
				count_q[cmd_q.cls] <= count_q[cmd_q.cls] + 1'b1;
			end
			if (state_q == ST_POP && rcnt_q != 2'd0) rcnt_q <= rcnt_q - 2'd1;
		end
	end

	a_rcnt: assert property (@(posedge clk) disable iff (!arst_n) rcnt_q <= 2'(NUM_CLASSES))
		else $error("round count overflow");
	a_res: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_POP |=> res_valid_q) else $error("missing result");
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !cmd_ready) else $error("ready while busy");
endmodule
`default_nettype wire

FILE: sv/deficit_round_robin_scheduler.sv
// Top level of the three-class deficit round robin scheduler.
// Instantiates drr_front and drr_back; depends on drr_pkg.
//
// Slave stream s_axis: one request per transfer, tuser = req_type (0 enqueue,
// 1 dequeue), tdata = {pkt_tag, pkt_len, src_port}.
// Master stream m_axis: exactly one result per request, tdata as commented below.
// Config channel cfg_*: register index and data, written while the block is idle.
// An enqueue, or a dequeue that pops from a filled round buffer, passes through
// the command queue and one back-end state, which registers its result. A dequeue
// that runs a round visits each class in turn (FIFO memory read, then deficit
// compare if the class holds packets) and then pops.
// The back end takes a new request only from idle, once no result waits untaken.
// A two-entry command queue takes further requests while the back end works.
// Reset empties all class FIFOs, clears deficits and the round buffer and
// restores the default registers. When m_axis_tready is low the result holds
// and the back end stops; the front queue then fills and drops s_axis_tready.
`timescale 1ns / 1ps
`default_nettype none
module deficit_round_robin_scheduler (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input wire logic [47:0] s_axis_tdata, // src_port, pkt_len, pkt_tag
	input wire logic s_axis_tuser, // req_type
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	output logic [39:0] m_axis_tdata, // enq_accepted, out_valid, out_tag, out_len, out_class, pad
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [2:0] cfg_index,
	input wire logic [15:0] cfg_data
);
	import drr_pkg::*;
	logic [15:0] port_two_q, port_one_q, qz_q, qo_q, qt_q;
	logic [10:0] limit_q;
	logic cmd_valid, cmd_ready;
	cmd_t cmd;
	res_t res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_two_q <= 16'd9999;
			port_one_q <= 16'd8888;
			qz_q <= 16'd1200;
			qo_q <= 16'd800;
			qt_q <= 16'd400;
			limit_q <= 11'd1024;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_PORT_TWO: port_two_q <= cfg_data;
				CFG_PORT_ONE: port_one_q <= cfg_data;
				CFG_QUANT_ZERO: qz_q <= cfg_data;
				CFG_QUANT_ONE: qo_q <= cfg_data;
				CFG_QUANT_TWO: qt_q <= cfg_data;
				CFG_QUEUE_LIMIT: limit_q <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	drr_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.req_type(s_axis_tuser), .src_port(s_axis_tdata[15:0]),
		.pkt_len(s_axis_tdata[31:16]), .pkt_tag(s_axis_tdata[47:32]),
		.port_two(port_two_q), .port_one(port_one_q),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
	);

	drr_back u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
		.quant_zero(qz_q), .quant_one(qo_q), .quant_two(qt_q), .queue_limit(limit_q),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
	);

	assign m_axis_tdata = {4'd0, res.out_class, res.out_len, res.out_tag,
		res.out_valid, res.enq_accepted};
endmodule
`default_nettype wire

FILE: verif/deficit_round_robin_scheduler_tb.sv
// Self-checking bench for the three-class deficit round robin scheduler.
// Drives request and config traffic, predicts every result, compares on m_axis; uses drr_pkg.
`timescale 1ns / 1ps
module deficit_round_robin_scheduler_tb;
	import drr_pkg::*;

	typedef struct {
		req_t req;
		logic [15:0] port;
		logic [15:0] len;
		logic [15:0] tag;
	} request_t;

	typedef struct {
		logic accepted;
		logic pkt_valid;
		logic [15:0] tag;
		logic [15:0] len;
		logic [1:0] cls;
	} outcome_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic s_axis_tuser = 0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [39:0] m_axis_tdata;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	deficit_round_robin_scheduler uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// scheduler shadow state
	logic [15:0] port_two, port_one, quant[3];
	logic [10:0] limit_reg;
	logic [31:0] class_fifo[3][$];
	logic [17:0] credit[3];
	outcome_t round_list[$];

	request_t pending[$];
	outcome_t expected_results[$];
	int errors = 0;
	int n_stored = 0, n_dropped = 0, n_sent = 0, n_none = 0;
	bit quiet = 0;
	int hold_requests = 0, holds_done = 0;

	function automatic outcome_t schedule(request_t r);
		outcome_t o;
		outcome_t p;
		int c, lim;
		logic [18:0] d;
		o = '{0, 0, 0, 0, 0};
		if (r.req == REQ_ENQ) begin
			c = (r.port == port_two) ? 2 : (r.port == port_one) ? 1 : 0;
			lim = (limit_reg > QUEUE_DEPTH) ? QUEUE_DEPTH : limit_reg;
			if (class_fifo[c].size() < lim) begin
				class_fifo[c].insert(class_fifo[c].size(), {r.tag, r.len});
				o.accepted = 1;
				n_stored++;
			end else
				n_dropped++;
			return o;
		end
		if (round_list.size() == 0) begin
			for (c = 0; c < 3; c++) begin
				if (class_fifo[c].size() == 0)
					continue;
				d = credit[c] + quant[c];
				if (d > DEFICIT_MAX)
					d = DEFICIT_MAX;
				if (d >= class_fifo[c][0][15:0]) begin
					d = d - class_fifo[c][0][15:0];
					p = '{0, 1, class_fifo[c][0][31:16], class_fifo[c][0][15:0], c[1:0]};
					round_list.insert(round_list.size(), p);
					void'(class_fifo[c].pop_front());
				end
				credit[c] = d[17:0];
			end
		end
		if (round_list.size() != 0) begin
			o = round_list.pop_front();
			n_sent++;
		end else
			n_none++;
		return o;
	endfunction

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#(20 * 1000000);
		$display("RESULT: ERROR");
		$finish;
	end

	// request driver
	int src_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				expected_results.insert(expected_results.size(),
					schedule('{req_t'(s_axis_tuser), s_axis_tdata[15:0],
					s_axis_tdata[31:16], s_axis_tdata[47:32]}));
			if (s_axis_tvalid && !s_axis_tready) begin
				// hold
			end else if (src_gap > 0) begin
				src_gap <= src_gap - 1;
				s_axis_tvalid <= 0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				src_gap <= $urandom_range(0, 16);
				s_axis_tvalid <= 0;
			end else if (pending.size() > 0) begin
				request_t r;
				r = pending.pop_front();
				s_axis_tvalid <= 1;
				s_axis_tuser <= r.req;
				s_axis_tdata <= {r.tag, r.len, r.port};
			end else
				s_axis_tvalid <= 0;
		end
	end

	// result side: ready pattern and compare
	int sink_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_results.size() == 0) begin
					$error("result transfer with nothing expected");
					errors++;
				end else begin
					outcome_t e;
					e = expected_results.pop_front();
					if (m_axis_tdata[0] !== e.accepted) begin
						$error("enq_accepted exp %0h got %0h", e.accepted, m_axis_tdata[0]);
						errors++;
					end
					if (m_axis_tdata[1] !== e.pkt_valid) begin
						$error("out_valid exp %0h got %0h", e.pkt_valid, m_axis_tdata[1]);
						errors++;
					end
					if (m_axis_tdata[17:2] !== e.tag) begin
						$error("out_tag exp %0h got %0h", e.tag, m_axis_tdata[17:2]);
						errors++;
					end
					if (m_axis_tdata[33:18] !== e.len) begin
						$error("out_len exp %0h got %0h", e.len, m_axis_tdata[33:18]);
						errors++;
					end
					if (m_axis_tdata[35:34] !== e.cls) begin
						$error("out_class exp %0h got %0h", e.cls, m_axis_tdata[35:34]);
						errors++;
					end
				end
			end
			if (sink_gap > 0) begin
				sink_gap <= sink_gap - 1;
				m_axis_tready <= 0;
			end else if (holds_done < hold_requests) begin
				holds_done <= holds_done + 1;
				sink_gap <= 400;
				m_axis_tready <= 0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				sink_gap <= $urandom_range(0, 16);
				m_axis_tready <= 0;
			end else
				m_axis_tready <= 1;
		end
	end

	task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_valid <= 0;
		case (idx)
			CFG_PORT_TWO: port_two = val;
			CFG_PORT_ONE: port_one = val;
			CFG_QUANT_ZERO: quant[0] = val;
			CFG_QUANT_ONE: quant[1] = val;
			CFG_QUANT_TWO: quant[2] = val;
			CFG_QUEUE_LIMIT: limit_reg = val[10:0];
			default: ;
		endcase
	endtask

	task automatic configure(logic [15:0] p2, p1, q0, q1, q2, logic [10:0] lim);
		write_reg(CFG_PORT_TWO, p2);
		write_reg(CFG_PORT_ONE, p1);
		write_reg(CFG_QUANT_ZERO, q0);
		write_reg(CFG_QUANT_ONE, q1);
		write_reg(CFG_QUANT_TWO, q2);
		write_reg(CFG_QUEUE_LIMIT, {5'd0, lim});
	endtask

	task automatic drain();
		wait (pending.size() == 0 && !s_axis_tvalid && expected_results.size() == 0);
		repeat (30) @(posedge clk);
	endtask

	task automatic add(req_t q, logic [15:0] port, len, tag);
		request_t r;
		r = '{q, port, len, tag};
		pending.insert(pending.size(), r);
	endtask

	task automatic add_random(int n);
		logic [15:0] port, len;
		int k;
		repeat (n) begin
			k = $urandom_range(0, 9);
			port = (k < 3) ? port_two : (k < 6) ? port_one : 16'($urandom);
			len = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2500));
			if ($urandom_range(0, 99) < 45)
				add(REQ_DEQ, 16'($urandom), 16'($urandom), 16'($urandom));
			else
				add(REQ_ENQ, port, len, 16'($urandom));
		end
	endtask

	initial begin
		port_two = 9999; port_one = 8888;
		quant[0] = 1200; quant[1] = 800; quant[2] = 400;
		limit_reg = 1024;
		foreach (credit[i]) credit[i] = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;

		add(REQ_DEQ, 0, 0, 0);
		add(REQ_ENQ, 9999, 16'hffff, 16'hffff);
		add(REQ_ENQ, 8888, 0, 0);
		add(REQ_ENQ, 0, 1200, 16'h1234);
		add(REQ_ENQ, 16'hffff, 16'hffff, 16'h00ff);
		add(REQ_ENQ, 9999, 100, 16'hff00);
		add(REQ_ENQ, 8888, 900, 16'h5555);
		repeat (10) add(REQ_DEQ, 16'hffff, 16'hffff, 16'hffff);
		drain();

		// shared port goes to class 2; zero quanta let only empty packets through
		configure(77, 77, 0, 0, 0, 3);
		add(REQ_ENQ, 77, 0, 1);
		add(REQ_ENQ, 77, 5, 2);
		add(REQ_ENQ, 1, 0, 3);
		repeat (4) add(REQ_ENQ, 77, 0, 4);
		repeat (4) add(REQ_DEQ, 0, 0, 0);
		add_random(150);
		drain();

		configure(0, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 11'h7ff);
		add_random(200);
		drain();

		configure(16'hffff, 0, 100, 3000, 9000, 0);
		add_random(60);
		drain();

		// stall the sink long enough to back up the input
		configure(1234, 4321, 1500, 700, 300, 8);
		hold_requests = 1;
		add_random(250);
		drain();

		configure(16'($urandom), 16'($urandom), 16'($urandom_range(0, 3000)),
			16'($urandom_range(0, 3000)), 16'($urandom_range(0, 3000)), 1024);
		quiet = 1;
		add_random(400);
		drain();

		$display("Covered %0d stored and %0d dropped enqueues, %0d packets out, %0d empty dequeues",
			n_stored, n_dropped, n_sent, n_none);
		$display("over six register settings with random stalls and a long sink hold-off");
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
